### src/pidaw_pkg.sv
package pidaw_pkg;

  localparam int unsigned DATA_W           = 16;
  localparam int unsigned GAIN_FRAC_BITS   = 8;
  localparam int unsigned WINDUP_FRAC_BITS = 8;
  localparam int unsigned CFG_IDX_W        = 3;

  // Error is target minus measurement; the difference of two errors needs one bit more.
  localparam int unsigned ERR_W   = DATA_W + 1;
  localparam int unsigned DIFF_W  = ERR_W + 1;
  localparam int unsigned MAG_W   = ERR_W;
  // The anti-windup limit stays below 2^23, so a clamped integral fits in 25 signed bits.
  localparam int unsigned LIMIT_W = 24;
  localparam int unsigned INTEG_W = LIMIT_W + 1;
  localparam int unsigned ISUM_W  = 35;
  localparam int unsigned MUL_A_W = INTEG_W;
  localparam int unsigned MUL_B_W = DATA_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = PROD_W;

  localparam logic [DATA_W-1:0] GAIN_P_RST    = 16'd256;
  localparam logic [DATA_W-1:0] GAIN_I_RST    = 16'd0;
  localparam logic [DATA_W-1:0] GAIN_D_RST    = 16'd0;
  localparam logic [DATA_W-1:0] TARGET_RST    = 16'd0;
  localparam logic [DATA_W-1:0] DRIVE_MIN_RST = 16'h8000;
  localparam logic [DATA_W-1:0] DRIVE_MAX_RST = 16'h7FFF;
  localparam logic [DATA_W-1:0] WINDUP_RST    = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_TARGET    = 3'd3,
    REG_DRIVE_MIN = 3'd4,
    REG_DRIVE_MAX = 3'd5,
    REG_WINDUP    = 3'd6
  } pidaw_reg_e;

  typedef struct packed {
    logic                     action;
    logic signed [DATA_W-1:0] measured_value;
    logic [DATA_W-1:0]        elapsed_time;
  } pidaw_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive_value;
    logic                     integral_limited;
    logic                     drive_saturated;
  } pidaw_out_t;

  typedef enum logic [2:0] {
    MUL_LIM,
    MUL_ED,
    MUL_P,
    MUL_I,
    MUL_D
  } pidaw_mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } pidaw_acc_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LIM,
    S_MUL_ED,
    S_INTEG,
    S_ACC_P,
    S_ACC_I,
    S_DIV,
    S_ACC_D,
    S_OUT,
    S_CLEAR
  } pidaw_state_e;

  typedef struct packed {
    logic           load;
    logic           clear;
    pidaw_mul_sel_e mul_sel;
    logic           limit_we;
    logic           integ_we;
    pidaw_acc_op_e  acc_op;
    logic           out_we;
    logic           out_zero;
  } pidaw_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } pidaw_sts_t;

endpackage

### src/pidaw_div.sv
module pidaw_div #(
  parameter int unsigned NUM_W = pidaw_pkg::MAG_W,
  parameter int unsigned DEN_W = pidaw_pkg::DATA_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             fits;

  // Restoring division, one quotient bit per cycle; quotient bits shift in behind the dividend.
  assign trial     = {rem_q, quo_q[NUM_W-1]};
  assign fits      = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = {quo_q[NUM_W-2:0], fits};
      rem_d  = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_d  = cnt_q - CNT_W'(1);
      busy_d = cnt_q != CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

### src/pidaw_datapath.sv
module pidaw_datapath #(
  parameter int unsigned GAIN_FRAC_BITS = pidaw_pkg::GAIN_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pidaw_pkg::DATA_W-1:0]        cfg_wdata_i,
  input  pidaw_pkg::pidaw_in_t                in_req_i,
  input  pidaw_pkg::pidaw_cmd_t               cmd_i,
  output pidaw_pkg::pidaw_sts_t               sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pidaw_pkg::pidaw_out_t               out_req_o
);

  localparam int unsigned DW  = pidaw_pkg::DATA_W;
  localparam int unsigned EW  = pidaw_pkg::ERR_W;
  localparam int unsigned FW  = pidaw_pkg::DIFF_W;
  localparam int unsigned MW  = pidaw_pkg::MAG_W;
  localparam int unsigned LW  = pidaw_pkg::LIMIT_W;
  localparam int unsigned IW  = pidaw_pkg::INTEG_W;
  localparam int unsigned SW  = pidaw_pkg::ISUM_W;
  localparam int unsigned AW  = pidaw_pkg::MUL_A_W;
  localparam int unsigned BW  = pidaw_pkg::MUL_B_W;
  localparam int unsigned PW  = pidaw_pkg::PROD_W;
  localparam int unsigned CW  = pidaw_pkg::ACC_W;
  localparam logic [CW-1:0] RoundBias = CW'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  // Configuration registers.
  logic [DW-1:0] gain_p_q, gain_i_q, gain_d_q, target_q, dmin_q, dmax_q, windup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= pidaw_pkg::GAIN_P_RST;
      gain_i_q <= pidaw_pkg::GAIN_I_RST;
      gain_d_q <= pidaw_pkg::GAIN_D_RST;
      target_q <= pidaw_pkg::TARGET_RST;
      dmin_q   <= pidaw_pkg::DRIVE_MIN_RST;
      dmax_q   <= pidaw_pkg::DRIVE_MAX_RST;
      windup_q <= pidaw_pkg::WINDUP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pidaw_pkg::REG_GAIN_P:    gain_p_q <= cfg_wdata_i;
        pidaw_pkg::REG_GAIN_I:    gain_i_q <= cfg_wdata_i;
        pidaw_pkg::REG_GAIN_D:    gain_d_q <= cfg_wdata_i;
        pidaw_pkg::REG_TARGET:    target_q <= cfg_wdata_i;
        pidaw_pkg::REG_DRIVE_MIN: dmin_q   <= cfg_wdata_i;
        pidaw_pkg::REG_DRIVE_MAX: dmax_q   <= cfg_wdata_i;
        pidaw_pkg::REG_WINDUP:    windup_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Error and the error change that feeds the divider.
  logic signed [EW-1:0] err_d, err_q, prev_q;
  logic signed [FW-1:0] diff;
  logic [FW-1:0]        diff_abs;
  logic                 diff_neg_q;
  logic [DW-1:0]        dt_q;

  assign err_d    = EW'($signed(target_q)) - EW'($signed(in_req_i.measured_value));
  assign diff     = FW'(err_d) - FW'(prev_q);
  assign diff_abs = diff[FW-1] ? -diff : diff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q      <= err_d;
      dt_q       <= in_req_i.elapsed_time;
      diff_neg_q <= diff[FW-1];
    end
  end

  logic          div_busy;
  logic [MW-1:0] quot;

  pidaw_div #(
    .NUM_W(MW),
    .DEN_W(DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.load),
    .num_i  (diff_abs[MW-1:0]),
    .den_i  (in_req_i.elapsed_time),
    .busy_o (div_busy),
    .quot_o (quot)
  );

  logic signed [FW-1:0] deriv;

  always_comb begin
    if (dt_q == '0) begin
      deriv = '0;
    end else if (diff_neg_q) begin
      deriv = -$signed({1'b0, quot});
    end else begin
      deriv = $signed({1'b0, quot});
    end
  end

  // Larger magnitude of the two drive bounds.
  logic signed [EW-1:0] dmin_x, dmax_x;
  logic [EW-1:0]        abs_min, abs_max, bound;

  assign dmin_x  = EW'($signed(dmin_q));
  assign dmax_x  = EW'($signed(dmax_q));
  assign abs_min = dmin_x[EW-1] ? -dmin_x : dmin_x;
  assign abs_max = dmax_x[EW-1] ? -dmax_x : dmax_x;
  assign bound   = (abs_min > abs_max) ? abs_min : abs_max;

  // Shared multiplier with registered product.
  logic signed [IW-1:0] integ_q, integ_d;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod_q;

  always_comb begin
    case (cmd_i.mul_sel)
      pidaw_pkg::MUL_LIM: begin
        mul_a = $signed({{(AW-EW){1'b0}}, bound});
        mul_b = $signed({1'b0, windup_q});
      end
      pidaw_pkg::MUL_ED: begin
        mul_a = AW'(err_q);
        mul_b = $signed({1'b0, dt_q});
      end
      pidaw_pkg::MUL_P: begin
        mul_a = AW'(err_q);
        mul_b = BW'($signed(gain_p_q));
      end
      pidaw_pkg::MUL_I: begin
        mul_a = integ_q;
        mul_b = BW'($signed(gain_i_q));
      end
      default: begin
        mul_a = AW'(deriv);
        mul_b = BW'($signed(gain_d_q));
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(mul_a) * PW'(mul_b);
  end

  logic [LW-1:0] limit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.limit_we) begin
      limit_q <= prod_q[pidaw_pkg::WINDUP_FRAC_BITS +: LW];
    end
  end

  // Integral update with the anti-windup clamp.
  logic signed [SW-1:0] integ_raw, lim_pos;
  logic                 ilim_d, ilim_q;

  assign integ_raw = SW'(integ_q) + prod_q[SW-1:0];
  assign lim_pos   = $signed({{(SW-LW){1'b0}}, limit_q});

  always_comb begin
    ilim_d = 1'b0;
    if (integ_raw > lim_pos) begin
      integ_d = $signed({1'b0, limit_q});
      ilim_d  = 1'b1;
    end else if (integ_raw < -lim_pos) begin
      integ_d = -$signed({1'b0, limit_q});
      ilim_d  = 1'b1;
    end else begin
      integ_d = integ_raw[IW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else if (cmd_i.clear) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else if (cmd_i.integ_we) begin
      integ_q <= integ_d;
      prev_q  <= err_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.integ_we) begin
      ilim_q <= ilim_d;
    end
  end

  // Weighted sum.
  logic signed [CW-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.acc_op)
      pidaw_pkg::ACC_LOAD: acc_q <= prod_q;
      pidaw_pkg::ACC_ADD:  acc_q <= acc_q + prod_q;
      default: ;
    endcase
  end

  // Scale down with truncation toward zero, then clamp to the drive bounds.
  logic signed [CW-1:0] acc_biased, scaled, dmin_w, dmax_w;
  logic signed [DW-1:0] drive;
  logic                 dsat;

  assign acc_biased = acc_q + (acc_q[CW-1] ? $signed(RoundBias) : $signed(CW'(0)));
  assign scaled     = acc_biased >>> GAIN_FRAC_BITS;
  assign dmin_w     = CW'($signed(dmin_q));
  assign dmax_w     = CW'($signed(dmax_q));

  always_comb begin
    dsat = 1'b1;
    if (scaled > dmax_w) begin
      drive = $signed(dmax_q);
    end else if (scaled < dmin_w) begin
      drive = $signed(dmin_q);
    end else begin
      drive = scaled[DW-1:0];
      dsat  = 1'b0;
    end
  end

  // Output register.
  logic                  out_valid_q, out_valid_d;
  pidaw_pkg::pidaw_out_t out_req_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_we) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_we) begin
      if (cmd_i.out_zero) begin
        out_req_q <= '0;
      end else begin
        out_req_q.drive_value      <= drive;
        out_req_q.integral_limited <= ilim_q;
        out_req_q.drive_saturated  <= dsat;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_req_o       = out_req_q;
  assign sts_o.div_done  = !div_busy;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // The stored integral never leaves the band set by the anti-windup limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.integ_we && !cmd_i.clear |=>
      (integ_q <= $signed({1'b0, limit_q})) && (integ_q >= -$signed({1'b0, limit_q})))
    else $error("integral outside the anti-windup band");

  // A new division is never started on top of one still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

### src/pidaw_ctrl.sv
module pidaw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_action_i,
  output logic                  in_ready_o,
  input  pidaw_pkg::pidaw_sts_t sts_i,
  output pidaw_pkg::pidaw_cmd_t cmd_o
);

  pidaw_pkg::pidaw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pidaw_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.mul_sel = pidaw_pkg::MUL_LIM;
    cmd_o.acc_op  = pidaw_pkg::ACC_HOLD;
    unique case (state_q)
      pidaw_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i) begin
            cmd_o.clear = 1'b1;
            state_d     = pidaw_pkg::S_CLEAR;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = pidaw_pkg::S_MUL_LIM;
          end
        end
      end
      pidaw_pkg::S_MUL_LIM: begin
        cmd_o.mul_sel = pidaw_pkg::MUL_LIM;
        state_d       = pidaw_pkg::S_MUL_ED;
      end
      pidaw_pkg::S_MUL_ED: begin
        cmd_o.limit_we = 1'b1;
        cmd_o.mul_sel  = pidaw_pkg::MUL_ED;
        state_d        = pidaw_pkg::S_INTEG;
      end
      pidaw_pkg::S_INTEG: begin
        cmd_o.integ_we = 1'b1;
        cmd_o.mul_sel  = pidaw_pkg::MUL_P;
        state_d        = pidaw_pkg::S_ACC_P;
      end
      pidaw_pkg::S_ACC_P: begin
        // The integral term uses the value just clamped in the previous cycle.
        cmd_o.acc_op  = pidaw_pkg::ACC_LOAD;
        cmd_o.mul_sel = pidaw_pkg::MUL_I;
        state_d       = pidaw_pkg::S_ACC_I;
      end
      pidaw_pkg::S_ACC_I: begin
        cmd_o.acc_op = pidaw_pkg::ACC_ADD;
        state_d      = pidaw_pkg::S_DIV;
      end
      pidaw_pkg::S_DIV: begin
        cmd_o.mul_sel = pidaw_pkg::MUL_D;
        if (sts_i.div_done) begin
          state_d = pidaw_pkg::S_ACC_D;
        end
      end
      pidaw_pkg::S_ACC_D: begin
        cmd_o.acc_op = pidaw_pkg::ACC_ADD;
        state_d      = pidaw_pkg::S_OUT;
      end
      pidaw_pkg::S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_we = 1'b1;
          state_d      = pidaw_pkg::S_IDLE;
        end
      end
      pidaw_pkg::S_CLEAR: begin
        if (sts_i.out_free) begin
          cmd_o.out_we   = 1'b1;
          cmd_o.out_zero = 1'b1;
          state_d        = pidaw_pkg::S_IDLE;
        end
      end
      default: state_d = pidaw_pkg::S_IDLE;
    endcase
  end

  // Every accepted request moves the controller out of the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != pidaw_pkg::S_IDLE)
    else $error("accepted request did not start work");

  // A result is only written into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_we |-> sts_i.out_free)
    else $error("output register overwritten");

endmodule

### src/pid_controller_antiwindup.sv
// PID controller with an anti-windup clamp on the integral. Each request either clears the
// integral and the stored error (and returns an all-zero result) or runs one update from a
// measured value and an elapsed time, returning the clamped drive and two clamp flags. An
// update waits on the 17-step serial divider that forms the derivative, while the terms are
// built in turn on one shared 25 by 17 bit multiplier. Results wait in an output register;
// gains, setpoint, drive bounds and the windup factor are to be written through the register
// port between requests, which the block itself does not enforce.
module pid_controller_antiwindup #(
  parameter int unsigned GAIN_FRAC_BITS = pidaw_pkg::GAIN_FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pidaw_pkg::DATA_W-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  pidaw_pkg::pidaw_in_t            in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output pidaw_pkg::pidaw_out_t           out_req_o
);

  pidaw_pkg::pidaw_cmd_t cmd;
  pidaw_pkg::pidaw_sts_t sts;

  pidaw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_action_i(in_req_i.action),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pidaw_datapath #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_req_i   (in_req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o)
  );

endmodule
